// ===== rtl/core/cdt_pkg.sv =====
package cdt_pkg;

    // Command carried in the input tuser field
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_RESTART = 3'd3,
        OP_SAMPLE  = 3'd4,
        OP_SCAN    = 3'd5
    } op_t;

    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned TICK_W     = 8;
    localparam int unsigned ADC_W      = 10;
    localparam int unsigned SCAN_W     = 2;
    localparam int unsigned ANODE_W    = 3;
    localparam int unsigned SEG_W      = 7;
    localparam int unsigned COUNT_MAX  = 102;

    localparam logic [TICK_W-1:0] TICKS_RESET = 8'd125;

    // Scan positions: hundreds, tens, units
    localparam logic [SCAN_W-1:0] POS_HUNDREDS = 2'd0;
    localparam logic [SCAN_W-1:0] POS_TENS     = 2'd1;
    localparam logic [SCAN_W-1:0] POS_UNITS    = 2'd2;

    localparam logic [ANODE_W-1:0] ANODE_DARK = 3'b111;
    localparam logic [SEG_W-1:0]   SEG_DARK   = 7'h7F;

    // Drive for one scan position, active low
    typedef struct packed {
        logic [ANODE_W-1:0] anode;
        logic [SEG_W-1:0]   seg;
    } disp_t;

    // floor(v / 10) for v below 1024: multiply by 205, drop 11 bits
    function automatic logic [COUNT_W-1:0] div10(input logic [ADC_W-1:0] v);
        logic [17:0] prod;
        prod = 18'(v) * 18'd205;
        return prod[17:11];
    endfunction

    // Lit segments of a decimal digit, bit 0 is a, bit 6 is g (active high)
    function automatic logic [SEG_W-1:0] seg_lit(input logic [3:0] digit);
        logic [SEG_W-1:0] lit;
        case (digit)
            4'd0:    lit = 7'b0111111;
            4'd1:    lit = 7'b0000110;
            4'd2:    lit = 7'b1011011;
            4'd3:    lit = 7'b1001111;
            4'd4:    lit = 7'b1100110;
            4'd5:    lit = 7'b1101101;
            4'd6:    lit = 7'b1111101;
            4'd7:    lit = 7'b0100111;
            4'd8:    lit = 7'b1111111;
            4'd9:    lit = 7'b1101111;
            default: lit = 7'b0000000;
        endcase
        return lit;
    endfunction

endpackage

// ===== rtl/core/cdt_digit_mux.sv =====
module cdt_digit_mux (
    input  logic [cdt_pkg::COUNT_W-1:0] count,
    input  logic [cdt_pkg::SCAN_W-1:0]  pos,
    output cdt_pkg::disp_t              disp
);

    logic                         hundreds;
    logic [cdt_pkg::COUNT_W-1:0]  rest;
    logic [cdt_pkg::COUNT_W-1:0]  tens_q;
    logic [cdt_pkg::COUNT_W-1:0]  all_q;
    logic [cdt_pkg::COUNT_W-1:0]  units;
    logic [3:0]                   digit;

    always_comb
    begin
        hundreds = (count >= 7'd100);
        rest     = hundreds ? (count - 7'd100) : count;
        tens_q   = cdt_pkg::div10(10'(rest));
        all_q    = cdt_pkg::div10(10'(count));
        units    = count - 7'(all_q * 7'd10);

        case (pos)
            cdt_pkg::POS_TENS:
            begin
                digit     = tens_q[3:0];
                disp.anode = 3'b101;
            end
            cdt_pkg::POS_UNITS:
            begin
                digit     = units[3:0];
                disp.anode = 3'b011;
            end
            default:
            begin
                // hundreds, also the unused fourth code
                digit     = {3'b000, hundreds};
                disp.anode = 3'b110;
            end
        endcase

        disp.seg = ~cdt_pkg::seg_lit(digit);
    end

endmodule

// ===== rtl/core/countdown_timer_seven_segment_top.sv =====
// Channel | Direction | Handshake          | Payload
// s       | in        | s_tvalid/s_tready  | tuser[2:0] opcode; tdata[9:0] adc_sample
// m       | out       | m_tvalid/m_tready  | tdata: anode_drive, segment_drive, alarm_led,
//         |           |                    |        shown_count
// cfg     | in        | cfg_we (no wait)   | cfg_wdata[7:0] ticks_per_step
//
// One beat per cycle sustained while m_tready is high; each item passes through the input
// register, then the result register.
// rst_n is asynchronous, active low: count 0, counting off, sampling on, prescaler 0,
// scan at hundreds, ticks_per_step 125, both stages empty.
// When m_tready is low the result register holds; the input register still takes a
// beat if it is empty, then s_tready drops until the result moves on.
module countdown_timer_seven_segment_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] adc_sample, [15:10] zero
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] anode_drive, [9:3] segment_drive,
                                   // [10] alarm_led, [17:11] shown_count, [23:18] zero
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata  // ticks_per_step
);

    // Configuration
    logic [cdt_pkg::TICK_W-1:0]  ticks_reg;

    // Input stage
    logic                        in_valid_reg, in_valid_next;
    cdt_pkg::op_t                op_reg, op_next;
    logic [cdt_pkg::ADC_W-1:0]   adc_reg, adc_next;

    // Timer state
    logic [cdt_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        counting_reg, counting_next;
    logic                        sampling_reg, sampling_next;
    logic [cdt_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic [cdt_pkg::SCAN_W-1:0]  scan_reg, scan_next;

    // Result stage
    logic                        out_valid_reg, out_valid_next;
    logic [23:0]                 out_data_reg, out_data_next;

    logic                        advance;
    logic [cdt_pkg::TICK_W-1:0]  tick_inc;
    cdt_pkg::disp_t              disp;
    logic [cdt_pkg::ANODE_W-1:0] anode;
    logic [cdt_pkg::SEG_W-1:0]   seg;
    logic                        alarm;

    // Digit decode works on the count as it stands before this item
    cdt_digit_mux u_digit_mux (
        .count (count_reg),
        .pos   (scan_reg),
        .disp  (disp)
    );

    // Move the held item into the result register when that register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign tick_inc = tick_reg + 8'd1;

    // Input stage control
    always_comb
    begin
        in_valid_next = in_valid_reg;
        op_next       = op_reg;
        adc_next      = adc_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
            op_next       = cdt_pkg::op_t'(s_tuser[2:0]);
            adc_next      = s_tdata[9:0];
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Timer state update and result assembly for the item in the input register
    always_comb
    begin
        count_next    = count_reg;
        counting_next = counting_reg;
        sampling_next = sampling_reg;
        tick_next     = tick_reg;
        scan_next     = scan_reg;
        anode         = cdt_pkg::ANODE_DARK;
        seg           = cdt_pkg::SEG_DARK;

        if (advance)
        begin
            case (op_reg)
                cdt_pkg::OP_TICK:
                begin
                    // prescaler wraps at 8 bits; a step fires on a match
                    if (tick_inc == ticks_reg)
                    begin
                        tick_next = '0;
                        if (counting_reg && (count_reg != '0))
                        begin
                            count_next = count_reg - 7'd1;
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                cdt_pkg::OP_START:
                begin
                    counting_next = 1'b1;
                    sampling_next = 1'b0;
                end
                cdt_pkg::OP_STOP:
                begin
                    counting_next = 1'b0;
                end
                cdt_pkg::OP_RESTART:
                begin
                    sampling_next = 1'b1;
                    counting_next = 1'b0;
                end
                cdt_pkg::OP_SAMPLE:
                begin
                    if (sampling_reg)
                    begin
                        count_next = cdt_pkg::div10(adc_reg);
                    end
                end
                cdt_pkg::OP_SCAN:
                begin
                    anode = disp.anode;
                    seg   = disp.seg;
                    // advance hundreds, tens, units, back to hundreds
                    if (scan_reg == cdt_pkg::POS_HUNDREDS)
                    begin
                        scan_next = cdt_pkg::POS_TENS;
                    end
                    else if (scan_reg == cdt_pkg::POS_TENS)
                    begin
                        scan_next = cdt_pkg::POS_UNITS;
                    end
                    else
                    begin
                        scan_next = cdt_pkg::POS_HUNDREDS;
                    end
                end
                default:
                begin
                    // undefined commands leave the state alone
                end
            endcase
        end

        alarm = (count_next == '0) && !sampling_next;
    end

    // Result stage control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {6'd0, count_next, alarm, seg, anode};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg     <= cdt_pkg::TICKS_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            counting_reg  <= 1'b0;
            sampling_reg  <= 1'b1;
            tick_reg      <= '0;
            scan_reg      <= cdt_pkg::POS_HUNDREDS;
        end
        else
        begin
            if (cfg_we)
            begin
                ticks_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            counting_reg  <= counting_next;
            sampling_reg  <= sampling_next;
            tick_reg      <= tick_next;
            scan_reg      <= scan_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        adc_reg      <= adc_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    // Scan position never lands on the unused code
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg != 2'd3)
        else $error("scan position out of range");

    // Count never exceeds what a sample can preset
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 7'(cdt_pkg::COUNT_MAX))
        else $error("count above preset range");

    // Start turns counting on and sampling off
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg == cdt_pkg::OP_START) |=> counting_reg && !sampling_reg)
        else $error("start did not take effect");

    // Only a scan lights a digit
    a_dark: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg != cdt_pkg::OP_SCAN) |=> m_tdata[2:0] == cdt_pkg::ANODE_DARK)
        else $error("digit lit outside scan");

    // A held item is not dropped while the result stage is stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("stalled item lost");
`endif

endmodule
